// ===== rtl/core/dns_qname_encoder_assert.svh =====
// Assertion macros shared by the encoder's modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DNS_QNAME_ENCODER_ASSERT_SVH
`define DNS_QNAME_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DQE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DQE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dqe_pkg.sv =====
// Shared constants, types and command format of the hostname encoder.
// No dependencies; used by every module of the block.
package dqe_pkg;

  localparam int MAX_LABEL      = 63;
  localparam int MAX_NAME_BYTES = 512;
  localparam int CNT_W          = 6;
  localparam int LEN_W          = 10;
  localparam int SUM_W          = LEN_W + 1;
  localparam int BANKS_W        = 1;
  localparam int MEM_AW         = BANKS_W + CNT_W;
  localparam int QPTR_W         = 2;
  localparam int QDEPTH         = 1 << QPTR_W;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [MEM_AW-1:0] maddr_t;
  typedef logic [QPTR_W-1:0] qptr_t;
  typedef logic [QPTR_W:0]   qcnt_t;

  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_END        = 8'h00;
  localparam len_t       MAX_LEN_RESET = len_t'(496);
  localparam len_t       NAME_CAP      = len_t'(MAX_NAME_BYTES);
  localparam cnt_t       FLUSH_AT      = cnt_t'(MAX_LABEL - 1);
  localparam cnt_t       FULL_LABEL    = cnt_t'(MAX_LABEL);
  localparam logic       REG_MAX_LEN   = 1'b0;

  typedef enum logic [1:0] {
    CMD_LABEL,
    CMD_END,
    CMD_ERROR
  } cmd_kind_t;

  // One entry of the queue between classifier and emitter. An end command
  // with a nonzero count emits the pending label before the root byte.
  typedef struct packed {
    cmd_kind_t kind;
    cnt_t      cnt;
    logic      bank;
    len_t      total;
  } cmd_t;

  typedef struct packed {
    logic       we;
    maddr_t     addr;
    logic [7:0] data;
  } memwr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

// ===== rtl/core/dqe_front.sv =====
// Front end: accepts hostname bytes, tracks label and name state, writes
// label characters into the label memory and issues emit commands. Uses dqe_pkg.
`include "dns_qname_encoder_assert.svh"

module dqe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_ch,
  input  dqe_pkg::len_t     limit,
  input  logic              q_full,
  output logic              push,
  output dqe_pkg::cmd_t     push_cmd,
  output dqe_pkg::memwr_t   wr,
  input  dqe_pkg::release_t rel
);

  dqe_pkg::cnt_t lc_r, lc_nxt;
  dqe_pkg::len_t bw_r, bw_nxt;
  logic          ff_r, ff_nxt;
  logic          skip_r, skip_nxt;
  logic          wb_r, wb_nxt;
  logic [1:0]    busy_r, busy_nxt;

  logic          accept;
  dqe_pkg::sum_t sum_lbl, sum_full, total_end, lim_ext;

  assign in_ready = !q_full && !busy_r[wb_r];
  assign accept   = in_valid && in_ready;

  assign lim_ext   = dqe_pkg::sum_t'(limit);
  assign sum_lbl   = dqe_pkg::sum_t'(bw_r) + dqe_pkg::sum_t'(1) + dqe_pkg::sum_t'(lc_r);
  assign sum_full  = sum_lbl + dqe_pkg::sum_t'(1);
  assign total_end = (lc_r != '0) ? sum_lbl + dqe_pkg::sum_t'(1)
                                  : dqe_pkg::sum_t'(bw_r) + dqe_pkg::sum_t'(1);

  always_comb begin
    lc_nxt   = lc_r;
    bw_nxt   = bw_r;
    ff_nxt   = ff_r;
    skip_nxt = skip_r;
    wb_nxt   = wb_r;
    busy_nxt = busy_r;
    push     = 1'b0;
    push_cmd = '0;
    wr       = '0;
    push_cmd.bank = wb_r;
    push_cmd.cnt  = lc_r;

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (accept) begin
      if (skip_r) begin
        if (in_ch == dqe_pkg::CH_END) begin
          skip_nxt = 1'b0;
          lc_nxt   = '0;
          bw_nxt   = '0;
          ff_nxt   = 1'b0;
        end
      end else if (in_ch == dqe_pkg::CH_END) begin
        push   = 1'b1;
        lc_nxt = '0;
        bw_nxt = '0;
        ff_nxt = 1'b0;
        if (total_end >= lim_ext) begin
          push_cmd.kind = dqe_pkg::CMD_ERROR;
        end else begin
          push_cmd.kind  = dqe_pkg::CMD_END;
          push_cmd.total = dqe_pkg::len_t'(total_end);
          if (lc_r != '0) begin
            busy_nxt[wb_r] = 1'b1;
            wb_nxt         = ~wb_r;
          end
        end
      end else if (in_ch == dqe_pkg::CH_DOT) begin
        if (lc_r == '0) begin
          if (ff_r) begin
            ff_nxt = 1'b0;
          end else begin
            push          = 1'b1;
            push_cmd.kind = dqe_pkg::CMD_ERROR;
            bw_nxt        = '0;
            skip_nxt      = 1'b1;
          end
        end else if (sum_lbl >= lim_ext) begin
          push          = 1'b1;
          push_cmd.kind = dqe_pkg::CMD_ERROR;
          lc_nxt        = '0;
          bw_nxt        = '0;
          ff_nxt        = 1'b0;
          skip_nxt      = 1'b1;
        end else begin
          push           = 1'b1;
          push_cmd.kind  = dqe_pkg::CMD_LABEL;
          bw_nxt         = dqe_pkg::len_t'(sum_lbl);
          lc_nxt         = '0;
          busy_nxt[wb_r] = 1'b1;
          wb_nxt         = ~wb_r;
        end
      end else if (ff_r) begin
        // A character right after a flushed full label makes it overlong.
        push          = 1'b1;
        push_cmd.kind = dqe_pkg::CMD_ERROR;
        bw_nxt        = '0;
        ff_nxt        = 1'b0;
        skip_nxt      = 1'b1;
      end else begin
        wr.we   = 1'b1;
        wr.addr = {wb_r, lc_r};
        wr.data = in_ch;
        if (lc_r == dqe_pkg::FLUSH_AT) begin
          push = 1'b1;
          if (sum_full >= lim_ext) begin
            push_cmd.kind = dqe_pkg::CMD_ERROR;
            lc_nxt        = '0;
            bw_nxt        = '0;
            skip_nxt      = 1'b1;
          end else begin
            push_cmd.kind  = dqe_pkg::CMD_LABEL;
            push_cmd.cnt   = dqe_pkg::FULL_LABEL;
            bw_nxt         = dqe_pkg::len_t'(sum_full);
            lc_nxt         = '0;
            ff_nxt         = 1'b1;
            busy_nxt[wb_r] = 1'b1;
            wb_nxt         = ~wb_r;
          end
        end else begin
          lc_nxt = lc_r + dqe_pkg::cnt_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r   <= '0;
      bw_r   <= '0;
      ff_r   <= 1'b0;
      skip_r <= 1'b0;
      wb_r   <= 1'b0;
      busy_r <= '0;
    end else begin
      lc_r   <= lc_nxt;
      bw_r   <= bw_nxt;
      ff_r   <= ff_nxt;
      skip_r <= skip_nxt;
      wb_r   <= wb_nxt;
      busy_r <= busy_nxt;
    end
  end

  `DQE_ASSERT_NOW(a_skip_clean, skip_r, lc_r == '0 && bw_r == '0 && !ff_r, "name state not cleared while skipping")
  `DQE_ASSERT_NOW(a_write_free_bank, wr.we, !busy_r[wr.addr[dqe_pkg::MEM_AW-1]], "label write into a bank still being replayed")

endmodule

// ===== rtl/core/dqe_queue.sv =====
// Short command queue between the classifier and the emitter.
// Uses dqe_pkg for the command type and depth.
module dqe_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dqe_pkg::cmd_t push_cmd,
  input  logic          pop,
  output dqe_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  dqe_pkg::cmd_t  slots_r [dqe_pkg::QDEPTH];
  dqe_pkg::qptr_t wp_r, rp_r;
  dqe_pkg::qcnt_t cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == dqe_pkg::qcnt_t'(dqe_pkg::QDEPTH));
  assign head  = slots_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + dqe_pkg::qptr_t'(1);
      end
      if (pop) begin
        rp_r <= rp_r + dqe_pkg::qptr_t'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + dqe_pkg::qcnt_t'(1);
        2'b01:   cnt_r <= cnt_r - dqe_pkg::qcnt_t'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/dqe_back.sv =====
// Back end: holds the two-bank label memory and replays queued commands as
// wire bytes through a registered output stage. Uses dqe_pkg.
`include "dns_qname_encoder_assert.svh"

module dqe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dqe_pkg::cmd_t        q_head,
  input  logic                 q_empty,
  output logic                 pop,
  input  dqe_pkg::memwr_t      wr,
  output dqe_pkg::release_t    rel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  output logic                 out_error,
  output logic [dqe_pkg::LEN_W-1:0] out_name_length
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_LEN,
    B_CHAR,
    B_ROOT,
    B_ERR
  } bstate_t;

  logic [7:0] mem [1 << dqe_pkg::MEM_AW];
  logic [7:0] rdata_r;

  bstate_t       state_r, state_nxt;
  dqe_pkg::cmd_t cmd_r, cmd_nxt;
  dqe_pkg::cnt_t idx_r, idx_nxt;

  logic          out_valid_r;
  logic [7:0]    out_byte_r, byte_nxt;
  logic          out_last_r, last_nxt;
  logic          out_error_r, err_nxt;
  dqe_pkg::len_t out_len_r, len_nxt;
  logic          emit, emit_ok;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last        = out_last_r;
  assign out_error       = out_error_r;
  assign out_name_length = out_len_r;

  assign emit_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    pop       = 1'b0;
    rel       = '0;
    emit      = 1'b0;
    byte_nxt  = '0;
    last_nxt  = 1'b0;
    err_nxt   = 1'b0;
    len_nxt   = '0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          cmd_nxt = q_head;
          if (q_head.kind == dqe_pkg::CMD_ERROR) begin
            state_nxt = B_ERR;
          end else if (q_head.cnt == '0) begin
            state_nxt = B_ROOT;
          end else begin
            state_nxt = B_LEN;
          end
        end
      end
      B_LEN: begin
        if (emit_ok) begin
          emit      = 1'b1;
          byte_nxt  = 8'(cmd_r.cnt);
          idx_nxt   = '0;
          state_nxt = B_CHAR;
        end
      end
      B_CHAR: begin
        if (emit_ok) begin
          emit     = 1'b1;
          byte_nxt = rdata_r;
          if (idx_r == cmd_r.cnt - dqe_pkg::cnt_t'(1)) begin
            rel.valid = 1'b1;
            rel.bank  = cmd_r.bank;
            state_nxt = (cmd_r.kind == dqe_pkg::CMD_END) ? B_ROOT : B_IDLE;
          end else begin
            idx_nxt = idx_r + dqe_pkg::cnt_t'(1);
          end
        end
      end
      B_ROOT: begin
        if (emit_ok) begin
          emit      = 1'b1;
          last_nxt  = 1'b1;
          len_nxt   = cmd_r.total;
          state_nxt = B_IDLE;
        end
      end
      B_ERR: begin
        if (emit_ok) begin
          emit      = 1'b1;
          last_nxt  = 1'b1;
          err_nxt   = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // The read register always holds the entry at the replay index, since a
  // bank is never written while its label is being replayed.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[{cmd_r.bank, idx_nxt}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      idx_r   <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= byte_nxt;
        out_last_r  <= last_nxt;
        out_error_r <= err_nxt;
        out_len_r   <= len_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `DQE_ASSERT_NOW(a_idx_in_label, state_r == B_CHAR, idx_r < cmd_r.cnt, "replay index beyond label length")
  `DQE_ASSERT_NOW(a_error_shape, out_valid_r && out_error_r, out_last_r && out_byte_r == 8'd0 && out_len_r == '0, "malformed error result")
  `DQE_ASSERT_NEXT(a_pop_starts, pop, state_r != B_IDLE, "popped command not taken up")

endmodule

// ===== rtl/core/dns_qname_encoder.sv =====
// Input takes one item per cycle unless the 4-entry queue is full or the next label bank
// is still replayed; output replays each label as its length byte and its characters, and
// gives a single byte for an error or a bare root byte.
// Reset (rst_n, synchronous) clears the state registers, queue pointers and output valid
// and sets max_len to 496; the label memory and the command and index registers are not
// cleared.
module dns_qname_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_ch,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  output logic                        out_error,
  output logic [dqe_pkg::LEN_W-1:0]   out_name_length,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dqe_pkg::PADDR_W-1:0] paddr,
  input  logic [dqe_pkg::PDATA_W-1:0] pwdata,
  output logic [dqe_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  dqe_pkg::len_t     max_len_r;
  dqe_pkg::len_t     limit;
  logic              reg_sel;
  logic              q_full, q_empty, push, pop;
  dqe_pkg::cmd_t     push_cmd, q_head;
  dqe_pkg::memwr_t   wr;
  dqe_pkg::release_t rel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[dqe_pkg::PADDR_W-1] == dqe_pkg::REG_MAX_LEN);
  assign prdata  = reg_sel ? dqe_pkg::PDATA_W'(max_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= dqe_pkg::MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_len_r <= dqe_pkg::len_t'(pwdata);
    end
  end

  // Register values above the name cap act as the cap.
  assign limit = (max_len_r > dqe_pkg::NAME_CAP) ? dqe_pkg::NAME_CAP : max_len_r;

  dqe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .limit    (limit),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd),
    .wr       (wr),
    .rel      (rel)
  );

  dqe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  dqe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_empty         (q_empty),
    .pop             (pop),
    .wr              (wr),
    .rel             (rel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_error       (out_error),
    .out_name_length (out_name_length)
  );

endmodule

// ===== dv/dns_qname_encoder_checker.sv =====
// Checker for the hostname encoder: follows the input, output and register ports,
// predicts the wire bytes of every accepted item and compares them. Depends on dqe_pkg.
`timescale 1ns / 100ps

module dns_qname_encoder_checker
  import dqe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_ch,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         out_byte,
  input  logic               out_last,
  input  logic               out_error,
  input  logic [LEN_W-1:0]   out_name_length,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic [7:0] octet;
    logic       last;
    logic       err;
    len_t       name_len;
  } wire_byte_t;

  wire_byte_t wire_q[$];

  logic [7:0] label_buf [0:MAX_LABEL-1];
  int         label_cnt;
  int         name_bytes;
  bit         full_flushed;
  bit         skipping;
  len_t       max_len_q;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int buffer_limit();
    return (int'(max_len_q) < MAX_NAME_BYTES) ? int'(max_len_q) : MAX_NAME_BYTES;
  endfunction

  function automatic void push_wire(logic [7:0] octet, logic last, logic err, int name_len);
    wire_byte_t w;
    w.octet    = octet;
    w.last     = last;
    w.err      = err;
    w.name_len = len_t'(name_len);
    wire_q.push_back(w);
  endfunction

  function automatic void clear_name();
    label_cnt    = 0;
    name_bytes   = 0;
    full_flushed = 1'b0;
  endfunction

  function automatic void emit_label();
    push_wire(8'(label_cnt), 1'b0, 1'b0, 0);
    for (int i = 0; i < label_cnt; i++)
      push_wire(label_buf[i], 1'b0, 1'b0, 0);
    name_bytes = (name_bytes + 1 + label_cnt) & 'h3FF;
    label_cnt  = 0;
  endfunction

  function automatic void name_error(bit skip_rest);
    push_wire(8'h00, 1'b1, 1'b1, 0);
    clear_name();
    skipping = skip_rest;
  endfunction

  function automatic void encode_item(logic [7:0] ch);
    int total;
    if (skipping) begin
      if (ch == CH_END) begin
        skipping = 1'b0;
        clear_name();
      end
      return;
    end
    if (ch == CH_END) begin
      // The pending label and the root byte are checked against the limit together.
      total = name_bytes + ((label_cnt != 0) ? 1 + label_cnt : 0) + 1;
      if (total >= buffer_limit()) begin
        name_error(1'b0);
        return;
      end
      if (label_cnt != 0) emit_label();
      push_wire(8'h00, 1'b1, 1'b0, total);
      clear_name();
      return;
    end
    if (ch == CH_DOT) begin
      if (label_cnt == 0) begin
        // A dot right after a flushed full label only closes it.
        if (full_flushed) full_flushed = 1'b0;
        else name_error(1'b1);
        return;
      end
      if (name_bytes + 1 + label_cnt >= buffer_limit()) name_error(1'b1);
      else emit_label();
      return;
    end
    if (full_flushed) begin
      name_error(1'b1);
      return;
    end
    label_buf[label_cnt] = ch;
    label_cnt++;
    if (label_cnt >= MAX_LABEL) begin
      if (name_bytes + 1 + label_cnt >= buffer_limit()) begin
        name_error(1'b1);
      end else begin
        emit_label();
        full_flushed = 1'b1;
      end
    end
  endfunction

  function automatic void check_wire_byte();
    wire_byte_t w;
    if (wire_q.size() == 0) begin
      $error("result with no item pending: out_byte %0h out_last %0b out_error %0b length %0d",
             out_byte, out_last, out_error, out_name_length);
      fail_count++;
      return;
    end
    w = wire_q.pop_front();
    if (out_byte !== w.octet) begin
      $error("out_byte mismatch: expected %0h, actual %0h", w.octet, out_byte);
      fail_count++;
    end
    if (out_last !== w.last) begin
      $error("out_last mismatch: expected %0b, actual %0b", w.last, out_last);
      fail_count++;
    end
    if (out_error !== w.err) begin
      $error("out_error mismatch: expected %0b, actual %0b", w.err, out_error);
      fail_count++;
    end
    if (out_name_length !== w.name_len) begin
      $error("out_name_length mismatch: expected %0d, actual %0d", w.name_len, out_name_length);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_name();
      skipping  = 1'b0;
      max_len_q = MAX_LEN_RESET;
      wire_q.delete();
    end else begin
      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_MAX_LEN) begin
        if (pwrite) begin
          max_len_q = pwdata[LEN_W-1:0];
        end else if (prdata !== PDATA_W'(max_len_q)) begin
          $error("prdata mismatch: expected %0h, actual %0h", PDATA_W'(max_len_q), prdata);
          fail_count++;
        end
      end
      if (in_valid && in_ready) encode_item(in_ch);
      if (out_valid && out_ready) check_wire_byte();
    end
    pending <= wire_q.size();
  end

endmodule

// ===== dv/dns_qname_encoder_tb.sv =====
// Top of the hostname encoder testbench: clock, reset, hostname stimulus, register
// writes and the verdict. Depends on dqe_pkg, dns_qname_encoder and its checker.
`timescale 1ns / 100ps

module dns_qname_encoder_tb;
  import dqe_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 12;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [7:0]         in_ch     = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_byte;
  logic               out_last;
  logic               out_error;
  logic [LEN_W-1:0]   out_name_length;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int pending;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int stall_cycles   = 0;

  logic [7:0] host_q[$];

  always #5 clk = ~clk;

  dns_qname_encoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_error       (out_error),
    .out_name_length (out_name_length),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  dns_qname_encoder_checker u_encoding_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_error       (out_error),
    .out_name_length (out_name_length),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("dns_qname_encoder verification failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_host();
    foreach (host_q[i]) send_byte(host_q[i]);
  endtask

  // Waits until every predicted result has arrived, then for the drain period, for
  // items that were dropped without a result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes a register, then reads max_len back; the checker compares the read.
  task automatic program_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= PADDR_W'(REG_MAX_LEN) << 2;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (c == CH_DOT) c = 8'h2F;
    return c;
  endfunction

  // Mostly well-formed names with random labels; the rest are broken or raw bytes.
  task automatic send_random_name();
    int kind;
    int labels;
    int len;
    int pos;
    host_q.delete();
    kind = $urandom_range(99);
    if (kind < 80) begin
      labels = $urandom_range(0, 4);
      for (int l = 0; l < labels; l++) begin
        len = ($urandom_range(99) < 5) ? $urandom_range(62, 64) : $urandom_range(1, 10);
        repeat (len) host_q.push_back(label_char());
        if (l < labels - 1 || $urandom_range(3) == 0) host_q.push_back(CH_DOT);
      end
    end else if (kind < 88) begin
      repeat ($urandom_range(1, 6)) host_q.push_back(label_char());
      pos = $urandom_range(0, host_q.size());
      host_q.insert(pos, CH_DOT);
      host_q.insert(pos, CH_DOT);
    end else if (kind < 94) begin
      host_q.push_back(CH_DOT);
      repeat ($urandom_range(0, 5)) host_q.push_back(label_char());
    end else begin
      repeat ($urandom_range(1, 12))
        host_q.push_back(($urandom_range(3) == 0) ? CH_DOT : label_char());
    end
    host_q.push_back(CH_END);
    send_host();
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
      default: begin send_idle_pct = 38; recv_stall_pct = 38; end
    endcase
  endtask

  initial begin
    int limits [0:7];
    limits = '{1023, 2, 512, 24, 1, 70, 0, 496};
    limits[6] = $urandom_range(2, 512);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty name, extreme bytes with a trailing dot, lone dot,
    // doubled dot and leading dot, all at the reset limit.
    host_q = '{8'h00,
               8'h01, 8'hFF, 8'h2E, 8'h2D, 8'h2F, 8'h7F, 8'h80, 8'h2E, 8'h00,
               8'h2E, 8'h00,
               8'h41, 8'h2E, 8'h2E, 8'h42, 8'h00,
               8'h2E, 8'h41, 8'h00};
    send_host();
    drain();
    // Smallest working limit: only the bare root byte fits.
    program_reg(3'd0, 32'd2);
    host_q = '{8'h00, 8'h41, 8'h00};
    send_host();
    drain();
    program_reg(3'd0, 32'd0);
    host_q = '{8'h00};
    send_host();
    drain();
    // A write to an unused register index must leave max_len alone.
    program_reg(3'd0, 32'd496);
    program_reg(3'd4, 32'd2);
    host_q = '{8'h41, 8'h00};
    send_host();
    drain();

    for (int s = 0; s < 8; s++) begin
      set_idle_mode(s / 2);
      program_reg(3'd0, PDATA_W'(limits[s]));
      send_random_name();
      drain();
    end

    // Long receiver hold-off while the sender keeps going, so the input backs up.
    set_idle_mode(0);
    program_reg(3'd0, 32'd496);
    hold_req = 1'b1;
    host_q.delete();
    repeat (3) begin
      repeat (6) host_q.push_back(label_char());
      host_q.push_back(CH_DOT);
    end
    host_q.push_back(CH_END);
    send_host();
    drain();
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("dns_qname_encoder verification clean");
    end else begin
      $display("dns_qname_encoder verification failed");
    end
    $finish;
  end

endmodule
